>>> design/i64da_pkg.sv
// Shared types and constants for the signed 64-bit to decimal ASCII converter.
package i64da_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned NumDigits  = 20;
  localparam int unsigned BitCntW    = $clog2(ValueWidth);
  localparam int unsigned DigitPtrW  = $clog2(NumDigits);
  localparam int unsigned CharWidth  = 6;

  localparam logic [CharWidth-1:0] CharMinus = 6'd45;
  localparam logic [CharWidth-1:0] CharZero  = 6'd48;

  typedef logic [3:0] bcd_digit_t;
  typedef logic [NumDigits-1:0][3:0] bcd_vec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input and clear the BCD register
    logic shift;       // one shift-and-add-three step
    logic locate;      // point at the leading significant digit
    logic emit_sign;   // present the minus sign
    logic emit_digit;  // present the digit under the pointer
  } i64da_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bit_last;    // the final magnitude bit is being shifted in
    logic digit_last;  // the pointer is at the least significant digit
    logic negative;    // the captured value was negative
  } i64da_status_t;

endpackage

>>> design/i64da_ctrl.sv
// Controller state machine for the signed 64-bit to decimal ASCII converter.
module i64da_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  i64da_pkg::i64da_status_t status,
  output i64da_pkg::i64da_cmd_t    cmd,
  output logic                    busy
);

  typedef enum logic [2:0] {
    IDLE,
    CONVERT,
    LOCATE,
    SIGN,
    DIGITS
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            state <= CONVERT;
          end
        end
        CONVERT: begin
          if (status.bit_last) begin
            state <= LOCATE;
          end
        end
        LOCATE: begin
          state <= status.negative ? SIGN : DIGITS;
        end
        SIGN: begin
          state <= DIGITS;
        end
        DIGITS: begin
          if (status.digit_last) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = (state == IDLE) && start;
    cmd.shift      = (state == CONVERT);
    cmd.locate     = (state == LOCATE);
    cmd.emit_sign  = (state == SIGN);
    cmd.emit_digit = (state == DIGITS);
  end

  assign busy = (state != IDLE);

endmodule

>>> design/i64da_datapath.sv
// Datapath of the converter: magnitude, BCD register, counters and output register.
module i64da_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  i64da_pkg::i64da_cmd_t                   cmd,
  input  logic signed [i64da_pkg::ValueWidth-1:0] value,
  output i64da_pkg::i64da_status_t                status,
  output logic [i64da_pkg::CharWidth-1:0]         text_char,
  output logic                                   last_char,
  output logic                                   strobe
);

  logic [i64da_pkg::ValueWidth-1:0] mag;
  logic [i64da_pkg::ValueWidth-1:0] mag_load;
  logic                             negative;
  i64da_pkg::bcd_vec_t              bcd;
  i64da_pkg::bcd_vec_t              bcd_adj;
  logic [4*i64da_pkg::NumDigits-1:0] adj_flat;
  logic [i64da_pkg::BitCntW-1:0]    bit_cnt;
  logic [i64da_pkg::DigitPtrW-1:0]  ptr;
  logic [i64da_pkg::DigitPtrW-1:0]  lead_idx;
  i64da_pkg::bcd_digit_t            cur_digit;

  assign mag_load = value[i64da_pkg::ValueWidth-1] ? (~value + 1'b1) : value;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < i64da_pkg::NumDigits; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? (bcd[i] + 4'd3) : bcd[i];
    end
  end

  assign adj_flat = bcd_adj;

  // Highest non-zero digit; zero points at the units digit.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < i64da_pkg::NumDigits; i++) begin
      if (bcd[i] != 4'd0) begin
        lead_idx = i64da_pkg::DigitPtrW'(i);
      end
    end
  end

  assign cur_digit = bcd[ptr];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_load;
      negative <= value[i64da_pkg::ValueWidth-1];
      bcd      <= '0;
      bit_cnt  <= '0;
    end else if (cmd.shift) begin
      mag     <= {mag[i64da_pkg::ValueWidth-2:0], 1'b0};
      bcd     <= {adj_flat[4*i64da_pkg::NumDigits-2:0], mag[i64da_pkg::ValueWidth-1]};
      bit_cnt <= bit_cnt + 1'b1;
    end
    if (cmd.locate) begin
      ptr <= lead_idx;
    end else if (cmd.emit_digit) begin
      ptr <= ptr - 1'b1;
    end
    if (cmd.emit_sign) begin
      text_char <= i64da_pkg::CharMinus;
      last_char <= 1'b0;
    end else if (cmd.emit_digit) begin
      text_char <= i64da_pkg::CharZero + {2'b00, cur_digit};
      last_char <= (ptr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign || cmd.emit_digit;
    end
  end

  assign status.bit_last   = (bit_cnt == {i64da_pkg::BitCntW{1'b1}});
  assign status.digit_last = (ptr == '0);
  assign status.negative   = negative;

endmodule

>>> design/int64_to_decimal_ascii.sv
// Top level of the signed 64-bit integer to decimal ASCII text converter.
//
// Usage: drive value and raise start; the number is taken at the rising edge
// where start is high and busy is low. busy then stays high until the last
// character of that number has been issued.
// Each character leaves as one beat on text_char and last_char, marked by
// strobe for exactly one cycle. A negative number begins with a minus sign;
// digits follow most significant first with no leading zeros, and last_char
// is set on the final digit. Zero gives a single '0'.
// Conversion: the magnitude is turned into BCD by a shift-and-add-three loop
// that takes one bit per cycle, followed by the LOCATE state that finds the
// leading digit. The sign, if any, and the digits then leave the output
// register one per cycle. A new number is taken only once the controller
// is back in idle, after the last digit has been registered.
// Reset (synchronous, active high) returns the controller to idle and drops
// strobe; any conversion in progress is abandoned. The receiver cannot stall,
// so every character must be taken in the cycle in which strobe is high.
module int64_to_decimal_ascii (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [i64da_pkg::ValueWidth-1:0] value,
  output logic                                   strobe,
  output logic [i64da_pkg::CharWidth-1:0]         text_char,
  output logic                                   last_char
);

  i64da_pkg::i64da_cmd_t    cmd;
  i64da_pkg::i64da_status_t status;

  // The controller sequences load, conversion, leading-digit search and output.
  i64da_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the magnitude, the BCD digits and the output register.
  i64da_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .status    (status),
    .text_char (text_char),
    .last_char (last_char),
    .strobe    (strobe)
  );

endmodule
